@@ design/mpl_pkg.sv @@
// Shared types, constants and the quarter-wave sine ROM for the moving-panes
// LED color generator. No dependencies.
`default_nettype none
package mpl_pkg;

   localparam int MAX_COORD       = 1024;
   localparam int SINE_TABLE_BITS = 10;
   localparam int QSIZE           = 1 << SINE_TABLE_BITS;

   localparam int COORD_W = 10;
   localparam int SIZE_W  = 11;
   localparam int DVS_W   = 11;   // divisor: width, height or frame rate
   localparam int DVD_W   = 42;   // y * Y_SCALE + h/2 needs 42 bits
   localparam int PDVD_W  = 16;   // x * divisions
   localparam int DIV_STAGES = DVD_W;
   localparam int IDX_W   = SINE_TABLE_BITS + 1;

   localparam logic [31:0] Y_SCALE    = 32'd2734261102;
   localparam logic [31:0] PI4_TURN   = 32'd536598741;
   localparam logic [26:0] TICK_SCALE = 27'd68356528;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   typedef enum logic [2:0] {
      CSR_DIVISIONS  = 3'd0,
      CSR_SPEED      = 3'd1,
      CSR_FRAME_RATE = 3'd2,
      CSR_COLOR_A    = 3'd3,
      CSR_COLOR_B    = 3'd4
   } csr_index_type;

   localparam logic [5:0]  RST_DIVISIONS  = 6'd4;
   localparam logic [6:0]  RST_SPEED      = 7'd50;
   localparam logic [7:0]  RST_FRAME_RATE = 8'd60;
   localparam logic [23:0] RST_COLOR      = 24'd0;

   typedef struct packed {
      logic [5:0]  divisions;
      logic [6:0]  speed;
      logic [7:0]  frame_rate;
      logic [23:0] color_a;
      logic [23:0] color_b;
   } cfg_type;

   // one word queued between the front and the divider pipeline
   typedef struct packed {
      logic              action;
      logic              reverse;
      logic [DVD_W-1:0]  dvd;
      logic [DVS_W-1:0]  dvs;
      logic [PDVD_W-1:0] pdvd;
      logic [DVS_W-1:0]  pdvs;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic              action;
      logic              reverse;
      logic [DVS_W-1:0]  rem;
      logic [DVD_W-1:0]  dq;
      logic [DVS_W-1:0]  dvs;
      logic [DVS_W-1:0]  prem;
      logic [PDVD_W-1:0] pdq;
      logic [DVS_W-1:0]  pdvs;
   } div_stage_type;

   typedef struct packed {
      logic [1:0] count;
   } front_status_type;

   typedef logic [15:0] sine_rom_type [0:QSIZE];

   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      logic [63:0] x, x2, t, v;
      for (int i = 0; i <= QSIZE; i++) begin
         x  = (64'(i) * HALF_PI_Q30) / QSIZE;
         x2 = (x * x) >> 30;
         t  = ONE_Q30 - x2 / 110;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
         v  = (x * t) >> 30;
         v  = (v * 64'd65535 + (64'd1 << 29)) >> 30;
         if (v > 64'd65535) v = 64'd65535;
         rom[i] = v[15:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

endpackage
`default_nettype wire

@@ design/mpl_front.sv @@
// Front end: clamps geometry, forms dividends and divisors, and queues words
// for the divider pipeline in a two-entry queue. Depends on mpl_pkg.
`default_nettype none
module mpl_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mpl_pkg::cfg_type            cfg,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_action,
   input  wire logic [mpl_pkg::COORD_W-1:0] req_x_pos,
   input  wire logic [mpl_pkg::COORD_W-1:0] req_y_pos,
   input  wire logic [mpl_pkg::SIZE_W-1:0]  req_width,
   input  wire logic [mpl_pkg::SIZE_W-1:0]  req_height,
   input  wire logic                        req_reverse,
   input  wire logic                        pop,
   output logic                             head_valid,
   output mpl_pkg::entry_type               head,
   output mpl_pkg::front_status_type        status
);
   localparam logic [mpl_pkg::SIZE_W-1:0] MAXC = mpl_pkg::SIZE_W'(mpl_pkg::MAX_COORD);

   mpl_pkg::entry_type q_ff [0:1];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   mpl_pkg::entry_type word;
   logic [mpl_pkg::SIZE_W-1:0] wc, hc;
   logic [7:0] fr;
   logic push, do_pop;

   always_comb begin
      wc = (req_width == '0) ? mpl_pkg::SIZE_W'(1) : (req_width > MAXC) ? MAXC : req_width;
      hc = (req_height == '0) ? mpl_pkg::SIZE_W'(1) : (req_height > MAXC) ? MAXC : req_height;
      fr = (cfg.frame_rate == 8'd0) ? 8'd1 : cfg.frame_rate;
      word.action  = req_action;
      word.reverse = req_reverse;
      word.pdvd    = mpl_pkg::PDVD_W'(req_x_pos) * mpl_pkg::PDVD_W'(cfg.divisions);
      word.pdvs    = wc;
      if (req_action == mpl_pkg::ACT_TICK) begin
         word.dvd = mpl_pkg::DVD_W'(cfg.speed) * mpl_pkg::DVD_W'(mpl_pkg::TICK_SCALE)
                  + mpl_pkg::DVD_W'(fr >> 1);
         word.dvs = mpl_pkg::DVS_W'(fr);
      end else begin
         word.dvd = mpl_pkg::DVD_W'(req_y_pos) * mpl_pkg::DVD_W'(mpl_pkg::Y_SCALE)
                  + mpl_pkg::DVD_W'(hc >> 1);
         word.dvs = hc;
      end
   end

   assign req_ready    = (count_ff != 2'd2);
   assign push         = req_valid && req_ready;
   assign head_valid   = (count_ff != 2'd0);
   assign do_pop       = pop && head_valid;
   assign head         = q_ff[rptr_ff];
   assign status.count = count_ff;

   always_ff @(posedge clock) begin
      if (push) q_ff[wptr_ff] <= word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (do_pop) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(do_pop);
      end
   end
endmodule
`default_nettype wire

@@ design/mpl_div.sv @@
// Divider pipeline: one restoring quotient bit per stage for the angle or
// tick step, and for the pane index in the first stages. Depends on mpl_pkg.
`default_nettype none
module mpl_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_valid,
   input  wire mpl_pkg::entry_type   in_word,
   output mpl_pkg::div_stage_type    out_stage
);
   mpl_pkg::div_stage_type stg_ff [0:mpl_pkg::DIV_STAGES-1];
   mpl_pkg::div_stage_type first;

   function automatic mpl_pkg::div_stage_type div_step(mpl_pkg::div_stage_type cur,
                                                       logic pane_on);
      mpl_pkg::div_stage_type nxt;
      logic [mpl_pkg::DVS_W:0] t, pt;
      nxt = cur;
      t = {cur.rem, cur.dq[mpl_pkg::DVD_W-1]};
      if (t >= {1'b0, cur.dvs}) begin
         nxt.rem = mpl_pkg::DVS_W'(t - {1'b0, cur.dvs});
         nxt.dq  = {cur.dq[mpl_pkg::DVD_W-2:0], 1'b1};
      end else begin
         nxt.rem = t[mpl_pkg::DVS_W-1:0];
         nxt.dq  = {cur.dq[mpl_pkg::DVD_W-2:0], 1'b0};
      end
      pt = {cur.prem, cur.pdq[mpl_pkg::PDVD_W-1]};
      if (pane_on) begin
         if (pt >= {1'b0, cur.pdvs}) begin
            nxt.prem = mpl_pkg::DVS_W'(pt - {1'b0, cur.pdvs});
            nxt.pdq  = {cur.pdq[mpl_pkg::PDVD_W-2:0], 1'b1};
         end else begin
            nxt.prem = pt[mpl_pkg::DVS_W-1:0];
            nxt.pdq  = {cur.pdq[mpl_pkg::PDVD_W-2:0], 1'b0};
         end
      end
      return nxt;
   endfunction

   always_comb begin
      first.valid   = in_valid;
      first.action  = in_word.action;
      first.reverse = in_word.reverse;
      first.rem     = '0;
      first.dq      = in_word.dvd;
      first.dvs     = in_word.dvs;
      first.prem    = '0;
      first.pdq     = in_word.pdvd;
      first.pdvs    = in_word.pdvs;
   end

   for (genvar g = 0; g < mpl_pkg::DIV_STAGES; g++) begin : g_stage
      mpl_pkg::div_stage_type cur;
      if (g == 0) begin : g_head
         assign cur = first;
      end else begin : g_body
         assign cur = stg_ff[g-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[g].valid <= 1'b0;
         end else if (advance) begin
            stg_ff[g] <= div_step(cur, (g < mpl_pkg::PDVD_W));
         end
      end
   end

   assign out_stage = stg_ff[mpl_pkg::DIV_STAGES-1];
endmodule
`default_nettype wire

@@ design/mpl_shade.sv @@
// Back end: phase accumulator, sine ROM lookup, blend weight and per-channel
// blend into the result register. Depends on mpl_pkg.
`default_nettype none
module mpl_shade (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mpl_pkg::cfg_type       cfg,
   input  wire mpl_pkg::div_stage_type in_stage,
   output logic                        advance,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_red,
   output logic [7:0]                  rsp_green,
   output logic [7:0]                  rsp_blue
);
   logic [31:0] phase_ff;
   logic        a_valid_ff, a_odd_ff;
   logic [31:0] a_ang_ff;
   logic        b_valid_ff, b_odd_ff, b_neg_ff;
   logic [15:0] b_sample_ff;
   logic        c_valid_ff, c_odd_ff;
   logic [15:0] c_s_ff;
   logic        rsp_valid_ff;
   logic [7:0]  red_ff, green_ff, blue_ff;

   logic        odd;
   logic [31:0] ang_in;
   logic [mpl_pkg::IDX_W-1:0] idx;
   logic [16:0] sum;
   logic [23:0] c1, c2;

   function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, logic [15:0] s);
      logic [24:0] acc;
      acc = 25'(a) * (25'd65536 - 25'(s)) + 25'(b) * 25'(s) + 25'd32768;
      return acc[23:16];
   endfunction

   assign advance = !rsp_valid_ff || rsp_ready;
   assign odd     = in_stage.pdq[0];

   always_comb begin
      ang_in = in_stage.dq[31:0] + mpl_pkg::PI4_TURN;
      if (odd == in_stage.reverse) ang_in = ang_in + phase_ff;
      else                         ang_in = ang_in - phase_ff;
      // mirror the index in quadrants 1 and 3
      if (a_ang_ff[30]) idx = mpl_pkg::IDX_W'(mpl_pkg::QSIZE)
                            - mpl_pkg::IDX_W'(a_ang_ff[29 -: mpl_pkg::SINE_TABLE_BITS]);
      else              idx = mpl_pkg::IDX_W'(a_ang_ff[29 -: mpl_pkg::SINE_TABLE_BITS]);
      sum = b_neg_ff ? (17'd65536 - 17'(b_sample_ff)) : (17'd65536 + 17'(b_sample_ff));
      c1  = c_odd_ff ? cfg.color_b : cfg.color_a;
      c2  = c_odd_ff ? cfg.color_a : cfg.color_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         if (in_stage.valid && in_stage.action == mpl_pkg::ACT_TICK)
            phase_ff <= phase_ff + in_stage.dq[31:0];
         a_valid_ff   <= in_stage.valid && in_stage.action == mpl_pkg::ACT_PIXEL;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ang_ff    <= ang_in;
         a_odd_ff    <= odd;
         b_sample_ff <= mpl_pkg::SINE_ROM[idx];
         b_neg_ff    <= a_ang_ff[31];
         b_odd_ff    <= a_odd_ff;
         c_s_ff      <= sum[16:1];
         c_odd_ff    <= b_odd_ff;
         red_ff      <= blend(c1[7:0],   c2[7:0],   c_s_ff);
         green_ff    <= blend(c1[15:8],  c2[15:8],  c_s_ff);
         blue_ff     <= blend(c1[23:16], c2[23:16], c_s_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;
endmodule
`default_nettype wire

@@ design/moving_panes_led_color.sv @@
// Moving-panes LED color generator, top level.
// A pixel word is written into the queue on acceptance, then passes 42 divider stages and 4 shading
// stages before its color is shown. Throughput: one word per cycle unless a held result waits on
// rsp_ready, set by the bit-per-stage divider pipeline; tick words leave a bubble and no result.
// Synchronous reset clears phase, registers to defaults, queue and valids.
`default_nettype none
module moving_panes_led_color (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [9:0]  req_x_pos,
   input  wire logic [9:0]  req_y_pos,
   input  wire logic [10:0] req_width,
   input  wire logic [10:0] req_height,
   input  wire logic        req_reverse,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);
   mpl_pkg::cfg_type          cfg_ff;
   mpl_pkg::entry_type        head;
   mpl_pkg::div_stage_type    div_out;
   mpl_pkg::front_status_type fstat;
   logic head_valid, advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divisions  <= mpl_pkg::RST_DIVISIONS;
         cfg_ff.speed      <= mpl_pkg::RST_SPEED;
         cfg_ff.frame_rate <= mpl_pkg::RST_FRAME_RATE;
         cfg_ff.color_a    <= mpl_pkg::RST_COLOR;
         cfg_ff.color_b    <= mpl_pkg::RST_COLOR;
      end else if (csr_write) begin
         case (csr_index)
            mpl_pkg::CSR_DIVISIONS:  cfg_ff.divisions  <= csr_data[5:0];
            mpl_pkg::CSR_SPEED:      cfg_ff.speed      <= csr_data[6:0];
            mpl_pkg::CSR_FRAME_RATE: cfg_ff.frame_rate <= csr_data[7:0];
            mpl_pkg::CSR_COLOR_A:    cfg_ff.color_a    <= csr_data;
            mpl_pkg::CSR_COLOR_B:    cfg_ff.color_b    <= csr_data;
            default: ;
         endcase
      end
   end

   mpl_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_x_pos(req_x_pos), .req_y_pos(req_y_pos), .req_width(req_width),
      .req_height(req_height), .req_reverse(req_reverse),
      .pop(advance), .head_valid(head_valid), .head(head), .status(fstat)
   );

   mpl_div u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(head_valid), .in_word(head), .out_stage(div_out)
   );

   mpl_shade u_shade (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .in_stage(div_out),
      .advance(advance), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue)
   );

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fstat.count <= 2'd2)
      else $error("queue overfilled");
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> fstat.count == 2'd2)
      else $error("ready low with queue space");
endmodule
`default_nettype wire
